// ===== hw/rtl/pdarc_pkg.sv =====
// Shared types, widths, register indexes and the volt-scaling helper for the PD arc drive
// controller. Used by pdarc_cfg, pdarc_ctrl, pdarc_dp and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pdarc_pkg;

    // Fixed field widths.
    localparam int TURNS_W    = 17;
    localparam int HEAD_W     = 18;
    localparam int MS_W       = 16;
    localparam int VOLT_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Internal datapath widths that do not depend on the fraction bits.
    localparam int TURN_FRAC = 10;
    localparam int TRAVEL_W  = 23;
    localparam int ERR_W     = 24;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int HERR_W    = HEAD_W + 1;

    localparam int SPEED_LIMIT = 100;
    localparam int VOLT_LIMIT  = 12;
    // Smallest whole side value whose 12/100 scaling exceeds the volt limit.
    localparam int VOLT_SAT_WHOLE = 109;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT_MS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_BOOST  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HEADING_BOOST   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_PER_REV  = 3'd7;

    typedef struct packed {
        logic signed [15:0] target_distance;
        logic signed [17:0] target_heading;
        logic [15:0]        time_limit_ms;
        logic [15:0]        distance_gain;
        logic [15:0]        rate_gain;
        logic [3:0]         distance_boost;
        logic [3:0]         heading_boost;
        logic [15:0]        travel_per_rev;
    } cfg_t;

    // Operand selection of the shared multiplier.
    localparam logic [1:0] MUL_TRAVEL = 2'd0;
    localparam logic [1:0] MUL_PROP   = 2'd1;
    localparam logic [1:0] MUL_RATE   = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       err_en;
        logic       acc_en;
        logic       sum_en;
        logic       out_load;
    } cmd_t;

    // floor(whole * 12 / 100) for whole below VOLT_SAT_WHOLE, by a reciprocal multiply.
    // The constant 15732 / 2^17 overshoots 0.12 by too little to cross an integer here.
    function automatic logic [3:0] volts_of_whole(input logic [6:0] whole);
        logic [20:0] prod;
        prod = 21'(whole) * 21'd15732;
        return prod[20:17];
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/pdarc_cfg.sv =====
// Configuration register file of the PD arc drive controller.
// Depends on pdarc_pkg for the register indexes and the cfg_t layout.
`timescale 1ns / 1ps
`default_nettype none
module pdarc_cfg (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_wr_en,
    input  wire logic [pdarc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pdarc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pdarc_pkg::cfg_t                       cfg
);
    import pdarc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_DISTANCE: cfg_next.target_distance = cfg_wdata[15:0];
                REG_TARGET_HEADING:  cfg_next.target_heading  = cfg_wdata[17:0];
                REG_TIME_LIMIT_MS:   cfg_next.time_limit_ms   = cfg_wdata[15:0];
                REG_DISTANCE_GAIN:   cfg_next.distance_gain   = cfg_wdata[15:0];
                REG_RATE_GAIN:       cfg_next.rate_gain       = cfg_wdata[15:0];
                REG_DISTANCE_BOOST:  cfg_next.distance_boost  = cfg_wdata[3:0];
                REG_HEADING_BOOST:   cfg_next.heading_boost   = cfg_wdata[3:0];
                REG_TRAVEL_PER_REV:  cfg_next.travel_per_rev  = cfg_wdata[15:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_distance <= '0;
            cfg_reg.target_heading  <= '0;
            cfg_reg.time_limit_ms   <= 16'd1000;
            cfg_reg.distance_gain   <= 16'd1536;
            cfg_reg.rate_gain       <= 16'd8960;
            cfg_reg.distance_boost  <= 4'd1;
            cfg_reg.heading_boost   <= 4'd0;
            cfg_reg.travel_per_rev  <= 16'd1658;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/pdarc_ctrl.sv =====
// Sequencing state machine of the PD arc drive controller: input and result handshakes
// and the command word that steps the datapath. Depends on pdarc_pkg for cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module pdarc_ctrl (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output pdarc_pkg::cmd_t cmd
);
    import pdarc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_TRAVEL = 3'd1;
    localparam logic [2:0] ST_ERR    = 3'd2;
    localparam logic [2:0] ST_PROP   = 3'd3;
    localparam logic [2:0] ST_RATE   = 3'd4;
    localparam logic [2:0] ST_SUM    = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    // The result register can take a new result when empty or being drained this cycle.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_TRAVEL;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_TRAVEL;
                end
            end
            ST_TRAVEL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TRAVEL;
                state_next  = ST_ERR;
            end
            ST_ERR: begin
                cmd.err_en = 1'b1;
                state_next = ST_PROP;
            end
            ST_PROP: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_PROP;
                state_next  = ST_RATE;
            end
            ST_RATE: begin
                cmd.acc_en  = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE;
                state_next  = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/pdarc_dp.sv =====
// Datapath of the PD arc drive controller: input latches, one shared multiplier, error,
// speed and heading terms, volt scaling and the result register. Depends on pdarc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pdarc_dp #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  pdarc_pkg::cmd_t                            cmd,
    input  pdarc_pkg::cfg_t                            cfg,
    input  wire logic signed [pdarc_pkg::TURNS_W-1:0]  s_wheel_turns,
    input  wire logic signed [pdarc_pkg::HEAD_W-1:0]   s_heading_now,
    input  wire logic        [pdarc_pkg::MS_W-1:0]     s_elapsed_ms,
    input  wire logic                                  s_new_move,
    output logic signed      [pdarc_pkg::VOLT_W-1:0]   m_left_volts,
    output logic signed      [pdarc_pkg::VOLT_W-1:0]   m_right_volts,
    output logic                                       m_finished,
    output logic                                       m_timed_out
);
    import pdarc_pkg::*;

    localparam int SPD_W  = 8 + FRAC_BITS;
    localparam int TURN_W = ((FRAC_BITS + 5 > HEAD_W) ? FRAC_BITS + 5 : HEAD_W) + 1;
    localparam int SIDE_W = ((SPD_W > TURN_W) ? SPD_W : TURN_W) + 1;
    localparam int ACCURACY = ((1 << FRAC_BITS) + 5) / 10;
    localparam logic signed [SUM_W-1:0] SPEED_MAX = SUM_W'(SPEED_LIMIT) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] SPEED_MIN = -SPEED_MAX;

    logic signed [TURNS_W-1:0] turns_reg;
    logic signed [HEAD_W-1:0]  heading_reg;
    logic        [MS_W-1:0]    elapsed_reg;
    logic signed [ERR_W-1:0]   prev_reg;
    logic signed [ERR_W-1:0]   prev_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [SUM_W-1:0]   acc_reg;
    logic signed [SUM_W-1:0]   acc_next;
    logic signed [SPD_W-1:0]   speed_reg;
    logic signed [SPD_W-1:0]   speed_next;
    logic signed [TURN_W-1:0]  turn_reg;
    logic signed [TURN_W-1:0]  turn_next;
    logic signed [VOLT_W-1:0]  left_reg;
    logic signed [VOLT_W-1:0]  right_reg;
    logic                      finished_reg;
    logic                      timed_out_reg;

    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_A_W-1:0]  err_delta;
    logic signed [PROD_W-1:0]   travel_full;
    logic signed [TRAVEL_W-1:0] travel;
    logic signed [SUM_W-1:0]    prod_shift;
    logic signed [SUM_W-1:0]    dboost_fix;
    logic signed [SUM_W-1:0]    speed_sum;
    logic signed [HERR_W-1:0]   herr;
    logic signed [HERR_W-1:0]   herr_half;
    logic signed [TURN_W-1:0]   hboost_fix;
    logic signed [SIDE_W-1:0]   side_left;
    logic signed [SIDE_W-1:0]   side_right;
    logic        [ERR_W-1:0]    err_mag;
    logic                       timed_out;

    // Truncate a side toward zero to whole units, scale by 12/100 and saturate.
    function automatic logic signed [VOLT_W-1:0] side_to_volts(
        input logic signed [SIDE_W-1:0] side
    );
        logic [SIDE_W-1:0] mag;
        logic [SIDE_W-1:0] whole;
        logic [3:0]        v;
        mag   = side[SIDE_W-1] ? SIDE_W'(-side) : SIDE_W'(side);
        whole = mag >> FRAC_BITS;
        if (whole >= SIDE_W'(VOLT_SAT_WHOLE)) begin
            v = 4'(VOLT_LIMIT);
        end else begin
            v = volts_of_whole(whole[6:0]);
        end
        return side[SIDE_W-1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    endfunction

    // Shared multiplier operands.
    assign err_delta = MUL_A_W'(err_reg) - MUL_A_W'(prev_reg);

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_TRAVEL: begin
                mul_a = MUL_A_W'(turns_reg);
                mul_b = $signed({1'b0, cfg.travel_per_rev});
            end
            MUL_PROP: begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({1'b0, cfg.distance_gain});
            end
            MUL_RATE: begin
                mul_a = err_delta;
                mul_b = $signed({1'b0, cfg.rate_gain});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Distance error from the travel product.
    assign travel_full = prod_reg >>> TURN_FRAC;
    assign travel      = travel_full[TRAVEL_W-1:0];
    assign err_next    = ERR_W'(cfg.target_distance) - ERR_W'(travel);

    // Proportional part plus the sign boost, then the rate part and the clamp.
    assign prod_shift = SUM_W'(prod_reg >>> FRAC_BITS);
    assign dboost_fix = $signed(SUM_W'(cfg.distance_boost) << FRAC_BITS);

    always_comb begin
        if (err_reg > 0) begin
            acc_next = prod_shift + dboost_fix;
        end else if (err_reg < 0) begin
            acc_next = prod_shift - dboost_fix;
        end else begin
            acc_next = prod_shift;
        end
    end

    assign speed_sum = acc_reg + prod_shift;

    always_comb begin
        if (speed_sum > SPEED_MAX) begin
            speed_next = SPD_W'(SPEED_MAX);
        end else if (speed_sum < SPEED_MIN) begin
            speed_next = SPD_W'(SPEED_MIN);
        end else begin
            speed_next = SPD_W'(speed_sum);
        end
    end

    // Heading term: half the heading error plus its sign boost.
    assign herr       = HERR_W'(cfg.target_heading) - HERR_W'(heading_reg);
    assign herr_half  = herr >>> 1;
    assign hboost_fix = $signed(TURN_W'(cfg.heading_boost) << FRAC_BITS);

    always_comb begin
        if (herr > 0) begin
            turn_next = TURN_W'(herr_half) + hboost_fix;
        end else if (herr < 0) begin
            turn_next = TURN_W'(herr_half) - hboost_fix;
        end else begin
            turn_next = TURN_W'(herr_half);
        end
    end

    // A new move drops the stored error before this request uses it.
    always_comb begin
        prev_next = prev_reg;
        if (cmd.load_in && s_new_move) begin
            prev_next = '0;
        end else if (cmd.sum_en) begin
            prev_next = err_reg;
        end
    end

    assign side_left  = SIDE_W'(speed_reg) + SIDE_W'(turn_reg);
    assign side_right = SIDE_W'(speed_reg) - SIDE_W'(turn_reg);
    assign err_mag    = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign timed_out  = (elapsed_reg >= cfg.time_limit_ms);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
        end else begin
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            turns_reg   <= s_wheel_turns;
            heading_reg <= s_heading_now;
            elapsed_reg <= s_elapsed_ms;
        end
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.err_en) begin
            err_reg <= err_next;
        end
        if (cmd.acc_en) begin
            acc_reg <= acc_next;
        end
        if (cmd.sum_en) begin
            speed_reg <= speed_next;
            turn_reg  <= turn_next;
        end
        if (cmd.out_load) begin
            left_reg      <= side_to_volts(side_left);
            right_reg     <= side_to_volts(side_right);
            finished_reg  <= (err_mag <= ERR_W'(ACCURACY)) || timed_out;
            timed_out_reg <= timed_out;
        end
    end

    assign m_left_volts  = left_reg;
    assign m_right_volts = right_reg;
    assign m_finished    = finished_reg;
    assign m_timed_out   = timed_out_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/pd_arc_drive_controller_top.sv =====
// Top level of the PD arc drive controller: joins the register file, the sequencer and the
// datapath. Depends on pdarc_pkg, pdarc_cfg, pdarc_ctrl and pdarc_dp.
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      wheel_turns, heading_now, elapsed_ms, new_move
//   m_        out        m_valid / m_ready      left_volts, right_volts, finished, timed_out
//   cfg_      in         cfg_wr_en (no wait)    cfg_index, cfg_wdata
//
// After acceptance a request steps through the travel, error, proportional, rate, sum and output
// states to the result register, and no new request is taken until it is through: a single shared
// 25 x 17 multiplier is used three times in sequence (travel, proportional, rate term).
// The next request is taken from the cycle after the result is loaded, even while m_valid waits.
// A stalled m_ready holds the sequencer in its last step only when the result register is full.
// Reset is synchronous and active low; it restores register defaults and clears the stored error.
`timescale 1ns / 1ps
`default_nettype none
module pd_arc_drive_controller_top #(
    parameter int FRAC_BITS = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic signed [pdarc_pkg::TURNS_W-1:0]  s_wheel_turns,
    input  wire logic signed [pdarc_pkg::HEAD_W-1:0]   s_heading_now,
    input  wire logic        [pdarc_pkg::MS_W-1:0]     s_elapsed_ms,
    input  wire logic                                  s_new_move,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic signed      [pdarc_pkg::VOLT_W-1:0]   m_left_volts,
    output logic signed      [pdarc_pkg::VOLT_W-1:0]   m_right_volts,
    output logic                                       m_finished,
    output logic                                       m_timed_out,
    input  wire logic                                  cfg_wr_en,
    input  wire logic        [pdarc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [pdarc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import pdarc_pkg::*;

    cfg_t cfg;
    cmd_t cmd;

    pdarc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdarc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pdarc_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .cfg           (cfg),
        .s_wheel_turns (s_wheel_turns),
        .s_heading_now (s_heading_now),
        .s_elapsed_ms  (s_elapsed_ms),
        .s_new_move    (s_new_move),
        .m_left_volts  (m_left_volts),
        .m_right_volts (m_right_volts),
        .m_finished    (m_finished),
        .m_timed_out   (m_timed_out)
    );

endmodule
`default_nettype wire

// ===== verif/pd_arc_drive_controller_top_tb.sv =====
// Self-checking testbench for pd_arc_drive_controller_top: a PD distance loop with heading trim.
// Depends on pdarc_pkg and the RTL under hw/rtl; a small class predicts every drive command.
`timescale 1ns / 1ps
module pd_arc_drive_controller_top_tb;
    import pdarc_pkg::*;

    localparam int     FRAC        = 8;
    localparam longint ONE         = 64'sd1 << FRAC;
    localparam longint ACCURACY    = (ONE + 5) / 10;
    localparam longint I32_MAX     = 64'sd2147483647;
    localparam longint I32_MIN     = -64'sd2147483648;
    localparam int     QUIET_LIMIT = 4000;
    localparam int     PHASES      = 10;
    localparam int     PHASE_TICKS = 105;

    typedef struct {
        logic signed [TURNS_W-1:0] wheel_turns;
        logic signed [HEAD_W-1:0]  heading_now;
        logic [MS_W-1:0]           elapsed_ms;
        logic                      new_move;
    } tick_t;

    typedef struct {
        logic signed [VOLT_W-1:0] left_volts;
        logic signed [VOLT_W-1:0] right_volts;
        logic                     finished;
        logic                     timed_out;
    } drive_t;

    class arc_drive_checker;
        cfg_t   regs;
        int     prior_err;
        drive_t expected_drive[$];
        int     failures;

        function new();
            regs.target_distance = '0;
            regs.target_heading  = '0;
            regs.time_limit_ms   = 16'd1000;
            regs.distance_gain   = 16'd1536;
            regs.rate_gain       = 16'd8960;
            regs.distance_boost  = 4'd1;
            regs.heading_boost   = 4'd0;
            regs.travel_per_rev  = 16'd1658;
            prior_err = 0;
            failures  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_DISTANCE: regs.target_distance = data[15:0];
                REG_TARGET_HEADING:  regs.target_heading  = data[17:0];
                REG_TIME_LIMIT_MS:   regs.time_limit_ms   = data[15:0];
                REG_DISTANCE_GAIN:   regs.distance_gain   = data[15:0];
                REG_RATE_GAIN:       regs.rate_gain       = data[15:0];
                REG_DISTANCE_BOOST:  regs.distance_boost  = data[3:0];
                REG_HEADING_BOOST:   regs.heading_boost   = data[3:0];
                REG_TRAVEL_PER_REV:  regs.travel_per_rev  = data[15:0];
                default: ;
            endcase
        endfunction

        function longint sign_of(longint v);
            return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
        endfunction

        // Whole part truncates toward zero, as does the 12/100 scaling.
        function logic signed [VOLT_W-1:0] side_volts(longint side);
            longint whole;
            longint v;
            whole = side / ONE;
            v = (whole * 12) / 100;
            if (v > VOLT_LIMIT) v = VOLT_LIMIT;
            if (v < -VOLT_LIMIT) v = -VOLT_LIMIT;
            return v[VOLT_W-1:0];
        endfunction

        function drive_t predict_drive(tick_t t);
            longint turns, head, td, th, dg, rg, db, hb, tpr;
            longint travel, err, speed, herr, turn, mag;
            logic   tmo;
            drive_t r;
            turns = t.wheel_turns;
            head  = t.heading_now;
            td    = regs.target_distance;
            th    = regs.target_heading;
            dg    = regs.distance_gain;
            rg    = regs.rate_gain;
            db    = regs.distance_boost;
            hb    = regs.heading_boost;
            tpr   = regs.travel_per_rev;
            if (t.new_move) prior_err = 0;

            // Arithmetic shifts on signed values round toward minus infinity.
            travel = (turns * tpr) >>> TURN_FRAC;
            err    = td - travel;
            speed  = ((err * dg) >>> FRAC) + (((err - prior_err) * rg) >>> FRAC)
                   + sign_of(err) * db * ONE;
            if (speed > SPEED_LIMIT * ONE) speed = SPEED_LIMIT * ONE;
            if (speed < -SPEED_LIMIT * ONE) speed = -SPEED_LIMIT * ONE;

            herr = th - head;
            turn = (herr >>> 1) + sign_of(herr) * hb * ONE;

            if (err > I32_MAX) prior_err = I32_MAX;
            else if (err < I32_MIN) prior_err = I32_MIN;
            else prior_err = int'(err);

            mag = (err < 0) ? -err : err;
            tmo = t.elapsed_ms >= regs.time_limit_ms;
            r.left_volts  = side_volts(speed + turn);
            r.right_volts = side_volts(speed - turn);
            r.finished    = (mag <= ACCURACY) || tmo;
            r.timed_out   = tmo;
            return r;
        endfunction

        function void note_tick(tick_t t);
            expected_drive.push_back(predict_drive(t));
        endfunction

        function void check_drive(drive_t got);
            drive_t want;
            if (expected_drive.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: drive result with no request pending", $time);
                return;
            end
            want = expected_drive.pop_front();
            if (got.left_volts !== want.left_volts || got.right_volts !== want.right_volts ||
                got.finished !== want.finished || got.timed_out !== want.timed_out) begin
                failures++;
                if (failures <= 10)
                    $display("%0t: expected L=%0d R=%0d fin=%0b tmo=%0b, got L=%0d R=%0d fin=%0b tmo=%0b",
                             $time, want.left_volts, want.right_volts, want.finished,
                             want.timed_out, got.left_volts, got.right_volts, got.finished,
                             got.timed_out);
            end
        endfunction

        function int pending();
            return expected_drive.size();
        endfunction
    endclass

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                        s_valid       = 1'b0;
    logic                        s_ready;
    logic signed [TURNS_W-1:0]   s_wheel_turns = '0;
    logic signed [HEAD_W-1:0]    s_heading_now = '0;
    logic [MS_W-1:0]             s_elapsed_ms  = '0;
    logic                        s_new_move    = 1'b0;
    logic                        m_valid;
    logic                        m_ready       = 1'b0;
    logic signed [VOLT_W-1:0]    m_left_volts;
    logic signed [VOLT_W-1:0]    m_right_volts;
    logic                        m_finished;
    logic                        m_timed_out;
    logic                        cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index     = '0;
    logic [CFG_DATA_W-1:0]       cfg_wdata     = '0;

    arc_drive_checker sb;
    bit     gaps_on     = 1'b1;
    bit     rx_hold_req = 1'b0;
    int     ticks_sent  = 0;
    int     quiet_cycles = 0;
    tick_t  seen_tick;
    drive_t seen_drive;

    pd_arc_drive_controller_top #(.FRAC_BITS(FRAC)) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_wheel_turns (s_wheel_turns),
        .s_heading_now (s_heading_now),
        .s_elapsed_ms  (s_elapsed_ms),
        .s_new_move    (s_new_move),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_left_volts  (m_left_volts),
        .m_right_volts (m_right_volts),
        .m_finished    (m_finished),
        .m_timed_out   (m_timed_out),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Observe every handshake and register write; also guards against a hung block.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) sb.write_reg(cfg_index, cfg_wdata);
            if (m_valid && m_ready) begin
                seen_drive = '{m_left_volts, m_right_volts, m_finished, m_timed_out};
                sb.check_drive(seen_drive);
            end
            if (s_valid && s_ready) begin
                seen_tick = '{s_wheel_turns, s_heading_now, s_elapsed_ms, s_new_move};
                sb.note_tick(seen_tick);
            end
            if (cfg_wr_en || (m_valid && m_ready) || (s_valid && s_ready)) begin
                quiet_cycles = 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("pd_arc_drive_controller_top_tb: FAIL");
                $finish;
            end else begin
                quiet_cycles++;
            end
        end
    end

    // Result side: random back-pressure, plus one long hold-off when asked.
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (150) @(posedge aclk);
            end
            m_ready <= !(gaps_on && $urandom_range(99) < 26);
        end
    end

    function automatic tick_t mk_tick(longint turns, longint head, longint ms, bit fresh);
        tick_t t;
        t.wheel_turns = turns[TURNS_W-1:0];
        t.heading_now = head[HEAD_W-1:0];
        t.elapsed_ms  = ms[MS_W-1:0];
        t.new_move    = fresh;
        return t;
    endfunction

    // Valid stays high from one request to the next unless a gap is drawn.
    task automatic send_tick(input tick_t t);
        while (gaps_on && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_wheel_turns <= t.wheel_turns;
        s_heading_now <= t.heading_now;
        s_elapsed_ms  <= t.elapsed_ms;
        s_new_move    <= t.new_move;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
    endtask

    // The first edge lets the monitor note a request accepted at the current edge.
    task automatic wait_drained();
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, longint data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data[CFG_DATA_W-1:0];
        @(posedge aclk);
    endtask

    task automatic program_regs(longint td, longint th, longint tl, longint dg, longint rg,
                                longint db, longint hb, longint tpr);
        put_reg(REG_TARGET_DISTANCE, td);
        put_reg(REG_TARGET_HEADING, th);
        put_reg(REG_TIME_LIMIT_MS, tl);
        put_reg(REG_DISTANCE_GAIN, dg);
        put_reg(REG_RATE_GAIN, rg);
        put_reg(REG_DISTANCE_BOOST, db);
        put_reg(REG_HEADING_BOOST, hb);
        put_reg(REG_TRAVEL_PER_REV, tpr);
        cfg_wr_en <= 1'b0;
    endtask

    // A move: the wheels close in on the target over a few ticks, time rising steadily but for rare random jumps.
    // Some moves lack the opening new-move flag or get a stray one in the middle.
    task automatic run_move();
        int     n;
        int     step;
        longint goal, turns, ms, head, td, tpr;
        bit     fresh;
        n    = $urandom_range(12, 3);
        step = $urandom_range(15, 5);
        td   = sb.regs.target_distance;
        tpr  = sb.regs.travel_per_rev;
        if (tpr != 0) goal = (td * 1024) / tpr;
        else goal = longint'($urandom_range(131071)) - 65536;
        for (int k = 0; k < n; k++) begin
            turns = goal * k / (n - 1);
            if ($urandom_range(3) == 0) turns += longint'($urandom_range(8)) - 4;
            if (turns > 65535) turns = 65535;
            if (turns < -65536) turns = -65536;
            ms = k * step + $urandom_range(3);
            if ($urandom_range(9) == 0) ms = $urandom_range(65535);
            head = longint'(sb.regs.target_heading) + longint'($urandom_range(4000)) - 2000;
            fresh = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
            send_tick(mk_tick(turns, head, ms, fresh));
        end
    endtask

    task automatic noise_tick();
        longint head;
        if ($urandom_range(1) == 0) head = longint'($urandom_range(184320)) - 92160;
        else head = $urandom();
        send_tick(mk_tick($urandom(), head, $urandom(), $urandom_range(1)));
    endtask

    initial begin
        bit paused;
        sb = new();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: zero errors, accuracy edges, time-limit edges, field extremes.
        send_tick(mk_tick(0, 0, 0, 1));
        send_tick(mk_tick(16, 0, 10, 0));
        send_tick(mk_tick(17, 0, 20, 0));
        send_tick(mk_tick(-16, 0, 30, 0));
        send_tick(mk_tick(-17, 0, 40, 0));
        send_tick(mk_tick(1, 1, 50, 0));
        send_tick(mk_tick(-1, -1, 60, 0));
        send_tick(mk_tick(0, 0, 999, 0));
        send_tick(mk_tick(0, 0, 1000, 0));
        send_tick(mk_tick(0, 0, 65535, 1));
        send_tick(mk_tick(65535, 92160, 0, 1));
        send_tick(mk_tick(-65536, -92160, 0, 0));
        send_tick(mk_tick(65535, -131072, 0, 0));
        send_tick(mk_tick(-65536, 131071, 65535, 0));
        end_burst();
        wait_drained();

        // Full boosts: a zero error must add none, a tiny heading error gets the whole boost.
        program_regs(0, 0, 1000, 1536, 8960, 15, 15, 1658);
        send_tick(mk_tick(0, 0, 0, 1));
        send_tick(mk_tick(0, 2, 10, 0));
        send_tick(mk_tick(0, -2, 20, 0));
        send_tick(mk_tick(100, 5000, 30, 0));
        send_tick(mk_tick(-100, -5000, 40, 0));
        end_burst();
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: program_regs(32767, 92160, 65535, 65535, 65535, 15, 15, 65535);
                1: program_regs(-32768, -92160, 0, 0, 0, 0, 0, 0);
                2: program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                $urandom(), $urandom(), $urandom());
                default: program_regs(longint'($urandom_range(25600)) - 12800,
                                      longint'($urandom_range(46080)) - 23040,
                                      $urandom_range(2000, 50), $urandom_range(4096),
                                      $urandom_range(16384), $urandom_range(15),
                                      $urandom_range(15), $urandom_range(3000, 800));
            endcase
            gaps_on = (phase != 5);
            if (phase == 4) rx_hold_req = 1'b1;
            paused = 1'b0;
            while (ticks_sent < 19 + (phase + 1) * PHASE_TICKS) begin
                if ($urandom_range(99) < 80) run_move();
                else noise_tick();
                // Let the pipeline run completely dry once in the middle of a phase.
                if (phase == 6 && !paused && ticks_sent >= 19 + phase * PHASE_TICKS + 50) begin
                    end_burst();
                    wait_drained();
                    paused = 1'b1;
                end
            end
            end_burst();
            wait_drained();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("pd_arc_drive_controller_top_tb: PASS");
        else
            $display("pd_arc_drive_controller_top_tb: FAIL");
        $finish;
    end

endmodule

// ===== pd_arc_drive_controller_top.f =====
hw/rtl/pdarc_pkg.sv
hw/rtl/pdarc_cfg.sv
hw/rtl/pdarc_ctrl.sv
hw/rtl/pdarc_dp.sv
hw/rtl/pd_arc_drive_controller_top.sv
verif/pd_arc_drive_controller_top_tb.sv
